### rtl/core/rom_enc_pkg.sv
// Shared constants, letter codes and numeral table lookups for the Roman numeral encoder.
`timescale 1ns / 1ps
`default_nettype none

package rom_enc_pkg;

	localparam int VALUE_W     = 12;
	localparam int LETTER_W    = 8;
	localparam int ENTRY_COUNT = 13;
	localparam int ENTRY_W     = 4;
	localparam int QUEUE_DEPTH = 2;

	// ASCII codes of the numeral letters; a zero code marks a one-letter entry.
	localparam logic [LETTER_W-1:0] LETTER_NONE = 8'h00;
	localparam logic [LETTER_W-1:0] LETTER_I    = 8'h49;
	localparam logic [LETTER_W-1:0] LETTER_V    = 8'h56;
	localparam logic [LETTER_W-1:0] LETTER_X    = 8'h58;
	localparam logic [LETTER_W-1:0] LETTER_L    = 8'h4C;
	localparam logic [LETTER_W-1:0] LETTER_C    = 8'h43;
	localparam logic [LETTER_W-1:0] LETTER_D    = 8'h44;
	localparam logic [LETTER_W-1:0] LETTER_M    = 8'h4D;

	localparam logic [VALUE_W-1:0] ENTRY_VALUE [ENTRY_COUNT] = '{
		12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
		12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
	};

	localparam logic [LETTER_W-1:0] ENTRY_FIRST [ENTRY_COUNT] = '{
		LETTER_M, LETTER_C, LETTER_D, LETTER_C, LETTER_C, LETTER_X, LETTER_L,
		LETTER_X, LETTER_X, LETTER_I, LETTER_V, LETTER_I, LETTER_I
	};

	localparam logic [LETTER_W-1:0] ENTRY_SECOND [ENTRY_COUNT] = '{
		LETTER_NONE, LETTER_M, LETTER_NONE, LETTER_D, LETTER_NONE, LETTER_C, LETTER_NONE,
		LETTER_L, LETTER_NONE, LETTER_X, LETTER_NONE, LETTER_V, LETTER_NONE
	};

	// Index of the largest table entry that does not exceed the remainder.
	// The table is descending, so the first entry that fits wins.
	function automatic logic [ENTRY_W-1:0] find_entry(input logic [VALUE_W-1:0] rem);
		logic [ENTRY_W-1:0] idx;
		logic               found;
		idx   = ENTRY_W'(ENTRY_COUNT - 1);
		found = 1'b0;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			if (!found && rem >= ENTRY_VALUE[i]) begin
				idx   = ENTRY_W'(i);
				found = 1'b1;
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

### rtl/core/rom_enc_front.sv
// Input stage: takes items, drops zero values and pushes the rest into the queue.
`timescale 1ns / 1ps
`default_nettype none

module rom_enc_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             value_valid,
	output logic                                  value_ready,
	input  wire logic [rom_enc_pkg::VALUE_W-1:0]  value,
	input  wire logic                             q_full,
	output logic                                  q_push,
	output logic      [rom_enc_pkg::VALUE_W-1:0]  q_data
);
	import rom_enc_pkg::*;

	logic               valid_s1;
	logic [VALUE_W-1:0] value_s1;
	logic               is_zero;
	logic               leave;

	// A zero value yields no letters, so it retires without a queue slot.
	assign is_zero     = (value_s1 == '0);
	assign leave       = valid_s1 && (is_zero || !q_full);
	assign q_push      = valid_s1 && !is_zero && !q_full;
	assign q_data      = value_s1;
	assign value_ready = !valid_s1 || leave;

	// Holding register for the item being classified.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (value_ready) begin
			valid_s1 <= value_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (value_ready && value_valid) begin
			value_s1 <= value;
		end
	end

endmodule

`default_nettype wire

### rtl/core/rom_enc_queue.sv
// Short FIFO that decouples the input stage from the letter sequencer.
`timescale 1ns / 1ps
`default_nettype none

module rom_enc_queue #(
	parameter int Depth = rom_enc_pkg::QUEUE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	input  wire logic [rom_enc_pkg::VALUE_W-1:0]  push_data,
	output logic                                  full,
	input  wire logic                             pop,
	output logic                                  empty,
	output logic      [rom_enc_pkg::VALUE_W-1:0]  pop_data
);
	import rom_enc_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [VALUE_W-1:0] mem_q [Depth];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (count_q == CntW'(Depth));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Pointers wrap at the depth, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage entries.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### rtl/core/rom_enc_back.sv
// Letter sequencer: expands a value greedily, one letter per cycle unless the output stalls.
`timescale 1ns / 1ps
`default_nettype none

module rom_enc_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             q_empty,
	input  wire logic [rom_enc_pkg::VALUE_W-1:0]  q_data,
	output logic                                  q_pop,
	output logic                                  letter_valid,
	input  wire logic                             letter_ready,
	output logic      [rom_enc_pkg::LETTER_W-1:0] letter,
	output logic                                  last
);
	import rom_enc_pkg::*;

	logic                busy_q;
	logic [VALUE_W-1:0]  rem_q;
	logic                pend_q;
	logic [LETTER_W-1:0] pend_letter_q;
	logic                out_valid_q;
	logic [LETTER_W-1:0] letter_q;
	logic                last_q;

	logic                advance;
	logic [ENTRY_W-1:0]  idx;
	logic [VALUE_W-1:0]  diff;
	logic [LETTER_W-1:0] first_l;
	logic [LETTER_W-1:0] second_l;
	logic                first_last;

	assign advance      = !out_valid_q || letter_ready;
	assign q_pop        = !busy_q && !q_empty;
	assign letter_valid = out_valid_q;
	assign letter       = letter_q;
	assign last         = last_q;

	// Pick the largest entry that fits; while busy the remainder is zero only when a second letter is pending.
	always_comb begin
		idx        = find_entry(rem_q);
		diff       = rem_q - ENTRY_VALUE[idx];
		first_l    = ENTRY_FIRST[idx];
		second_l   = ENTRY_SECOND[idx];
		first_last = (second_l == LETTER_NONE) && (diff == '0);
	end

	// Sequencer state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				pend_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= busy_q;
				if (busy_q) begin
					if (pend_q) begin
						pend_q <= 1'b0;
						busy_q <= (rem_q != '0);
					end else begin
						pend_q <= (second_l != LETTER_NONE);
						busy_q <= !first_last;
					end
				end
			end
		end
	end

	// Payload registers: remainder, pending second letter and the letter shown.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rem_q <= q_data;
		end else if (advance && busy_q) begin
			if (pend_q) begin
				letter_q <= pend_letter_q;
				last_q   <= (rem_q == '0);
			end else begin
				letter_q      <= first_l;
				last_q        <= first_last;
				rem_q         <= diff;
				pend_letter_q <= second_l;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/integer_to_roman_encoder.sv
// Top level of the integer to Roman numeral encoder.
//
//   Channel  Signals                          Direction  Payload
//   value    value_valid / value_ready        in         value[11:0]
//   letter   letter_valid / letter_ready      out        letter[7:0], last
//
// A value occupies the sequencer for a load of the remainder from the queue, then
// one letter per cycle while the output is not stalled. The sequencer sets the rate;
// zero values retire in the input stage and produce no letters.
// Reset is asynchronous and clears all handshake and sequencing state.
// A stalled output holds the sequencer while the queue keeps taking items until it is full.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_roman_encoder #(
	parameter int QueueDepth = rom_enc_pkg::QUEUE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             value_valid,
	output logic                                  value_ready,
	input  wire logic [rom_enc_pkg::VALUE_W-1:0]  value,
	output logic                                  letter_valid,
	input  wire logic                             letter_ready,
	output logic      [rom_enc_pkg::LETTER_W-1:0] letter,
	output logic                                  last
);
	import rom_enc_pkg::*;

	logic               q_push;
	logic [VALUE_W-1:0] q_push_data;
	logic               q_full;
	logic               q_pop;
	logic               q_empty;
	logic [VALUE_W-1:0] q_pop_data;

	// Input stage.
	rom_enc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.value       (value),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_push_data)
	);

	// Decoupling queue.
	rom_enc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_data  (q_pop_data)
	);

	// Letter sequencer.
	rom_enc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_pop_data),
		.q_pop        (q_pop),
		.letter_valid (letter_valid),
		.letter_ready (letter_ready),
		.letter       (letter),
		.last         (last)
	);

endmodule

`default_nettype wire
